// ===== design/kvte_pkg.sv =====
// ----------------------------------------------------------------------------
// kvte_pkg
// Shared sizes, codes and bundle types of the key/value table engine.
// ----------------------------------------------------------------------------
package kvte_pkg;

    localparam int CAPACITY   = 64;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 32;
    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int ACT_W      = 3;
    localparam int INDEX_W    = 6;
    localparam int LIM_W      = 7;
    localparam int LIM_RESET  = 64;

    typedef enum logic [ACT_W-1:0] {
        ACT_LOOKUP = 3'd0,
        ACT_INSERT = 3'd1,
        ACT_UPDATE = 3'd2,
        ACT_UPSERT = 3'd3,
        ACT_ERASE  = 3'd4,
        ACT_READ   = 3'd5
    } action_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_EXEC
    } state_t;

    // control from the sequencer to every cell
    typedef struct packed {
        logic                  cmp_en;
        logic [ACT_W-1:0]      action;
        logic [KEY_BITS-1:0]   key;
        logic [IDX_BITS-1:0]   index;
        logic [CNT_BITS-1:0]   count;
        logic                  upd_en;
        logic                  ins_en;
        logic                  shift_en;
        logic [IDX_BITS-1:0]   pos;
        logic [VALUE_BITS-1:0] value;
    } cell_ctrl_t;

    // registered summary of the selected cell
    typedef struct packed {
        logic                  found;
        logic [IDX_BITS-1:0]   pos;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] value;
    } red_t;

endpackage

// ===== design/key_value_table_engine.sv =====
// ----------------------------------------------------------------------------
// key_value_table_engine
// Bounded key/value table in insertion order, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Usage:
//   A request transaction is taken on a clock edge with start high and busy
//   low; action, key, value and index are sampled on that edge.
//   Every request gives exactly one result transaction: done is high for one
//   cycle with ok, found_key, found_value, entry_total and is_empty valid.
//   The result passes the compare in the cells, the registered or-tree reduce
//   and the execute step before done is registered.
//   busy is high through the reduce and execute steps after acceptance, so a new
//   request is not taken until the previous one reaches its result.
//   A new request may be accepted in the same cycle in which done is shown.
//   Erase closes the gap by shifting every later cell down together.
//   The receiver cannot stall; each result is valid for its one cycle only.
//   capacity_limit is written through cfg_wr_en / cfg_wr_data, by the user only while
//   idle (the block does not enforce it); values above the table size act as the table size.
//   Reset empties the table (count zero) and sets capacity_limit to 64;
//   slot contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module key_value_table_engine (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [kvte_pkg::ACT_W-1:0]      action,
    input  logic [kvte_pkg::KEY_BITS-1:0]   key,
    input  logic [kvte_pkg::VALUE_BITS-1:0] value,
    input  logic [kvte_pkg::INDEX_W-1:0]    index,
    input  logic                            cfg_wr_en,
    input  logic [kvte_pkg::LIM_W-1:0]      cfg_wr_data,
    output logic                            done,
    output logic                            ok,
    output logic [kvte_pkg::KEY_BITS-1:0]   found_key,
    output logic [kvte_pkg::VALUE_BITS-1:0] found_value,
    output logic [kvte_pkg::CNT_BITS-1:0]   entry_total,
    output logic                            is_empty
);
    import kvte_pkg::*;

    state_t                state_reg;
    state_t                state_next;
    logic                  accept;

    logic [ACT_W-1:0]      action_reg;
    logic [KEY_BITS-1:0]   key_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic [LIM_W-1:0]      limit_reg;
    logic [CNT_BITS-1:0]   limit_eff;

    logic                  done_reg;
    logic                  done_next;
    logic                  ok_reg;
    logic                  ok_next;
    logic [KEY_BITS-1:0]   fkey_reg;
    logic [KEY_BITS-1:0]   fkey_next;
    logic [VALUE_BITS-1:0] fval_reg;
    logic [VALUE_BITS-1:0] fval_next;

    logic                  room;
    logic                  do_ins;
    logic                  do_upd;
    logic                  do_shift;

    cell_ctrl_t            ctrl;
    red_t                  red;
    logic [CAPACITY-1:0]                 sel_row;
    logic [CAPACITY-1:0][KEY_BITS-1:0]   key_row;
    logic [CAPACITY-1:0][VALUE_BITS-1:0] value_row;

    assign accept = start && (state_reg == ST_IDLE);

    // next state
    always_comb
    begin
        case (state_reg)
            ST_IDLE:   state_next = accept ? ST_REDUCE : ST_IDLE;
            ST_REDUCE: state_next = ST_EXEC;
            ST_EXEC:   state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // execute decision from the reduced row
    always_comb
    begin
        limit_eff = (limit_reg > LIM_W'(CAPACITY)) ? CNT_BITS'(CAPACITY)
                                                   : CNT_BITS'(limit_reg);
        room      = count_reg < limit_eff;
        do_ins    = 1'b0;
        do_upd    = 1'b0;
        do_shift  = 1'b0;
        ok_next   = 1'b0;
        fkey_next = '0;
        fval_next = '0;
        case (action_reg)
            ACT_LOOKUP:
            begin
                ok_next   = red.found;
                fval_next = red.found ? red.value : '0;
            end
            ACT_INSERT:
            begin
                do_ins  = !red.found && room;
                ok_next = do_ins;
            end
            ACT_UPDATE:
            begin
                do_upd    = red.found;
                ok_next   = red.found;
                fval_next = red.found ? value_reg : '0;
            end
            ACT_UPSERT:
            begin
                do_upd    = red.found;
                do_ins    = !red.found && room;
                ok_next   = do_upd || do_ins;
                fval_next = (do_upd || do_ins) ? value_reg : '0;
            end
            ACT_ERASE:
            begin
                do_shift = red.found;
                ok_next  = red.found;
            end
            ACT_READ:
            begin
                ok_next   = red.found;
                fkey_next = red.found ? red.key : '0;
                fval_next = red.found ? red.value : '0;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    // outputs of the sequencer: cell control, count and result transaction
    always_comb
    begin
        ctrl          = '0;
        ctrl.action   = accept ? action : action_reg;
        ctrl.key      = accept ? key : key_reg;
        ctrl.index    = IDX_BITS'(index);
        ctrl.count    = count_reg;
        ctrl.value    = value_reg;
        ctrl.pos      = red.pos;
        ctrl.cmp_en   = accept;
        count_next    = count_reg;
        done_next     = 1'b0;
        if (state_reg == ST_EXEC)
        begin
            ctrl.ins_en   = do_ins;
            ctrl.upd_en   = do_upd;
            ctrl.shift_en = do_shift;
            done_next     = 1'b1;
            if (do_ins)
                count_next = count_reg + CNT_BITS'(1);
            else if (do_shift)
                count_next = count_reg - CNT_BITS'(1);
        end
    end

    // row of slot cells, each fed by its upper neighbor
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [KEY_BITS-1:0]   nbr_k;
        logic [VALUE_BITS-1:0] nbr_v;
        if (i == CAPACITY - 1)
        begin : g_last
            assign nbr_k = '0;
            assign nbr_v = '0;
        end
        else
        begin : g_mid
            assign nbr_k = key_row[i + 1];
            assign nbr_v = value_row[i + 1];
        end
        kvte_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .cell_idx  (IDX_BITS'(i)),
            .ctrl      (ctrl),
            .nbr_key   (nbr_k),
            .nbr_value (nbr_v),
            .sel       (sel_row[i]),
            .key_out   (key_row[i]),
            .value_out (value_row[i])
        );
    end

    kvte_reduce u_reduce (
        .clk    (clk),
        .sel    (sel_row),
        .keys   (key_row),
        .values (value_row),
        .red    (red)
    );

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            limit_reg <= LIM_W'(LIM_RESET);
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            done_reg  <= done_next;
            if (cfg_wr_en)
                limit_reg <= cfg_wr_data;
        end
    end

    // request and result payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= action;
            key_reg    <= key;
            value_reg  <= value;
        end
        if (state_reg == ST_EXEC)
        begin
            ok_reg   <= ok_next;
            fkey_reg <= fkey_next;
            fval_reg <= fval_next;
        end
    end

    assign busy        = (state_reg != ST_IDLE);
    assign done        = done_reg;
    assign ok          = ok_reg;
    assign found_key   = fkey_reg;
    assign found_value = fval_reg;
    assign entry_total = count_reg;
    assign is_empty    = (count_reg == '0);

    // live keys are unique, so at most one cell is selected
    a_sel_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_REDUCE) |-> $onehot0(sel_row))
        else $error("more than one cell selected");

    // a result transaction follows only the execute step
    a_done_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_EXEC))
        else $error("result without execute step");

    // count never exceeds the table size
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(CAPACITY))
        else $error("entry count beyond table size");

    // an accepted request enters the reduce step
    a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == ST_REDUCE))
        else $error("accepted request not sequenced");

endmodule

// ===== design/kvte_cell.sv =====
// ----------------------------------------------------------------------------
// kvte_cell
// One table slot: holds a pair, flags itself selected, loads, updates or
// takes its upper neighbor's pair when the table closes a gap.
// ----------------------------------------------------------------------------
module kvte_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [kvte_pkg::IDX_BITS-1:0]   cell_idx,
    input  kvte_pkg::cell_ctrl_t            ctrl,
    input  logic [kvte_pkg::KEY_BITS-1:0]   nbr_key,
    input  logic [kvte_pkg::VALUE_BITS-1:0] nbr_value,
    output logic                            sel,
    output logic [kvte_pkg::KEY_BITS-1:0]   key_out,
    output logic [kvte_pkg::VALUE_BITS-1:0] value_out
);
    import kvte_pkg::*;

    logic                  sel_reg;
    logic                  sel_next;
    logic                  live;
    logic                  hit;
    logic [KEY_BITS-1:0]   key_reg;
    logic [KEY_BITS-1:0]   key_next;
    logic [VALUE_BITS-1:0] value_reg;
    logic [VALUE_BITS-1:0] value_next;

    // selection: key match for keyed actions, position match for read
    always_comb
    begin
        live = CNT_BITS'(cell_idx) < ctrl.count;
        case (ctrl.action)
            ACT_LOOKUP, ACT_INSERT, ACT_UPDATE, ACT_UPSERT, ACT_ERASE:
                hit = (key_reg == ctrl.key);
            ACT_READ:
                hit = (cell_idx == ctrl.index);
            default:
                hit = 1'b0;
        endcase
        sel_next = ctrl.cmp_en ? (live && hit) : sel_reg;
    end

    // pair update: shift down, append, or overwrite value
    always_comb
    begin
        key_next   = key_reg;
        value_next = value_reg;
        if (ctrl.shift_en && (cell_idx >= ctrl.pos))
        begin
            key_next   = nbr_key;
            value_next = nbr_value;
        end
        else if (ctrl.ins_en && (CNT_BITS'(cell_idx) == ctrl.count))
        begin
            key_next   = ctrl.key;
            value_next = ctrl.value;
        end
        else if (ctrl.upd_en && sel_reg)
        begin
            value_next = ctrl.value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sel_reg <= 1'b0;
        else
            sel_reg <= sel_next;
    end

    always_ff @(posedge clk)
    begin
        key_reg   <= key_next;
        value_reg <= value_next;
    end

    assign sel       = sel_reg;
    assign key_out   = key_reg;
    assign value_out = value_reg;

endmodule

// ===== design/kvte_reduce.sv =====
// ----------------------------------------------------------------------------
// kvte_reduce
// Collapses the row of selected cells into one registered summary: found
// flag, position and the pair of the selected cell.
// ----------------------------------------------------------------------------
module kvte_reduce (
    input  logic                                                  clk,
    input  logic [kvte_pkg::CAPACITY-1:0]                         sel,
    input  logic [kvte_pkg::CAPACITY-1:0][kvte_pkg::KEY_BITS-1:0] keys,
    input  logic [kvte_pkg::CAPACITY-1:0][kvte_pkg::VALUE_BITS-1:0] values,
    output kvte_pkg::red_t                                        red
);
    import kvte_pkg::*;

    red_t red_reg;
    red_t red_next;

    // or-tree over the row; at most one cell is selected
    always_comb
    begin
        red_next = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            red_next.found = red_next.found | sel[i];
            red_next.pos   = red_next.pos | (sel[i] ? IDX_BITS'(i) : '0);
            red_next.key   = red_next.key | (keys[i] & {KEY_BITS{sel[i]}});
            red_next.value = red_next.value | (values[i] & {VALUE_BITS{sel[i]}});
        end
    end

    always_ff @(posedge clk)
    begin
        red_reg <= red_next;
    end

    assign red = red_reg;

endmodule

// ===== dv/tb_key_value_table_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_key_value_table_engine
// Self-checking bench for the key/value table engine. A queue of request and
// capacity-write transactions feeds a clocked driver. A clocked monitor runs a
// table predictor on every accepted request and checks each done strobe
// against the oldest predicted result. A short directed pass is followed by
// random phases under different capacity limits.
// ----------------------------------------------------------------------------
module tb_key_value_table_engine;
    import kvte_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 4;
    localparam int DRAIN_CYCLES  = 8;
    localparam int POOL_SIZE     = 72;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 190;
    localparam int MAX_REPORTS   = 40;

    // action codes the block does not define
    localparam logic [ACT_W-1:0] ACT_RSVD_A = 3'd6;
    localparam logic [ACT_W-1:0] ACT_RSVD_B = 3'd7;

    typedef enum logic {
        TXN_REQ,
        TXN_CFG
    } txn_kind_t;

    typedef struct {
        txn_kind_t             kind;
        logic [ACT_W-1:0]      act;
        logic [KEY_BITS-1:0]   key;
        logic [VALUE_BITS-1:0] val;
        logic [INDEX_W-1:0]    idx;
        logic [LIM_W-1:0]      lim;
        int                    gap;
    } table_txn_t;

    typedef struct {
        logic                  ok;
        logic [KEY_BITS-1:0]   fkey;
        logic [VALUE_BITS-1:0] fval;
        logic [CNT_BITS-1:0]   total;
        logic                  empty;
    } table_result_t;

    // dut signals
    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  start       = 1'b0;
    logic [ACT_W-1:0]      action      = '0;
    logic [KEY_BITS-1:0]   key         = '0;
    logic [VALUE_BITS-1:0] value       = '0;
    logic [INDEX_W-1:0]    index       = '0;
    logic                  cfg_wr_en   = 1'b0;
    logic [LIM_W-1:0]      cfg_wr_data = '0;
    logic                  busy;
    logic                  done;
    logic                  ok;
    logic [KEY_BITS-1:0]   found_key;
    logic [VALUE_BITS-1:0] found_value;
    logic [CNT_BITS-1:0]   entry_total;
    logic                  is_empty;

    // predicted table contents
    logic [KEY_BITS-1:0]   model_keys [CAPACITY];
    logic [VALUE_BITS-1:0] model_vals [CAPACITY];
    int                    model_count = 0;
    logic [LIM_W-1:0]      model_limit = LIM_W'(LIM_RESET);

    // transaction queues and bookkeeping
    table_txn_t            pending_txns [$];
    table_result_t         result_queue [$];
    logic [KEY_BITS-1:0]   key_pool [POOL_SIZE];
    logic                  item_taken    = 1'b0;
    logic                  head_armed    = 1'b0;
    int                    hold_left     = 0;
    logic                  quiet_stretch = 1'b0;
    int                    cycle_count   = 0;
    int                    error_count   = 0;
    int                    requests_taken = 0;
    int                    results_checked = 0;
    int                    success_count = 0;
    int                    limits_written = 0;
    int                    peak_count    = 0;

    key_value_table_engine u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .key         (key),
        .value       (value),
        .index       (index),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .done        (done),
        .ok          (ok),
        .found_key   (found_key),
        .found_value (found_value),
        .entry_total (entry_total),
        .is_empty    (is_empty)
    );

    // clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // apply one request to the predicted table and return its result
    function automatic table_result_t predict_table(
        input logic [ACT_W-1:0]      act,
        input logic [KEY_BITS-1:0]   k,
        input logic [VALUE_BITS-1:0] v,
        input logic [INDEX_W-1:0]    idx
    );
        table_result_t r;
        int            pos;
        int            room;
        int            i;
        r    = '{default: '0};
        pos  = -1;
        room = (model_limit > CAPACITY) ? CAPACITY : int'(model_limit);
        for (i = 0; i < model_count; i++)
        begin
            if (pos < 0 && model_keys[i] == k)
                pos = i;
        end
        case (act)
            ACT_LOOKUP:
            begin
                if (pos >= 0)
                begin
                    r.ok   = 1'b1;
                    r.fval = model_vals[pos];
                end
            end
            ACT_INSERT, ACT_UPSERT:
            begin
                if (pos >= 0)
                begin
                    if (act == ACT_UPSERT)
                    begin
                        model_vals[pos] = v;
                        r.ok   = 1'b1;
                        r.fval = v;
                    end
                end
                else if (model_count < room)
                begin
                    model_keys[model_count] = k;
                    model_vals[model_count] = v;
                    model_count++;
                    r.ok = 1'b1;
                    if (act == ACT_UPSERT)
                        r.fval = v;
                end
            end
            ACT_UPDATE:
            begin
                if (pos >= 0)
                begin
                    model_vals[pos] = v;
                    r.ok   = 1'b1;
                    r.fval = v;
                end
            end
            ACT_ERASE:
            begin
                if (pos >= 0)
                begin
                    // close the gap, keeping insertion order
                    for (i = pos; i + 1 < model_count; i++)
                    begin
                        model_keys[i] = model_keys[i + 1];
                        model_vals[i] = model_vals[i + 1];
                    end
                    model_count--;
                    r.ok = 1'b1;
                end
            end
            ACT_READ:
            begin
                if (int'(idx) < model_count)
                begin
                    r.ok   = 1'b1;
                    r.fkey = model_keys[idx];
                    r.fval = model_vals[idx];
                end
            end
            default:
            begin
            end
        endcase
        r.total = CNT_BITS'(model_count);
        r.empty = (model_count == 0);
        if (model_count > peak_count)
            peak_count = model_count;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    endtask

    // queue one request transaction with a random lead-in gap
    task automatic add_request(input logic [ACT_W-1:0] act, input logic [KEY_BITS-1:0] k,
                               input logic [VALUE_BITS-1:0] v, input logic [INDEX_W-1:0] idx);
        table_txn_t t;
        int         roll;
        roll   = $urandom_range(0, 99);
        t.kind = TXN_REQ;
        t.act  = act;
        t.key  = k;
        t.val  = v;
        t.idx  = idx;
        t.lim  = '0;
        if (quiet_stretch || roll < 55)
            t.gap = 0;
        else if (roll < 90)
            t.gap = $urandom_range(1, 3);
        else
            t.gap = $urandom_range(4, 24);
        pending_txns.push_back(t);
    endtask

    // queue a capacity write; the driver holds it until the block is idle
    task automatic add_config(input logic [LIM_W-1:0] lim);
        table_txn_t t;
        t.kind = TXN_CFG;
        t.act  = '0;
        t.key  = '0;
        t.val  = '0;
        t.idx  = '0;
        t.lim  = lim;
        t.gap  = SETTLE_CYCLES;
        pending_txns.push_back(t);
    endtask

    // driver: inputs change on the falling edge
    always @(negedge clk)
    begin
        table_txn_t head;
        logic       drive_start;
        logic       drive_cfg;
        drive_start = start;
        drive_cfg   = 1'b0;
        if (rst_n && !(start && !item_taken))
        begin
            drive_start = 1'b0;
            if (pending_txns.size() != 0)
            begin
                head = pending_txns[0];
                if (!head_armed)
                begin
                    hold_left  = head.gap;
                    head_armed = 1'b1;
                end
                if (head.kind == TXN_CFG && result_queue.size() != 0)
                    hold_left = SETTLE_CYCLES;
                else if (hold_left != 0)
                    hold_left--;
                else
                begin
                    head       = pending_txns.pop_front();
                    head_armed = 1'b0;
                    if (head.kind == TXN_REQ)
                    begin
                        drive_start = 1'b1;
                        action <= head.act;
                        key    <= head.key;
                        value  <= head.val;
                        index  <= head.idx;
                    end
                    else
                    begin
                        drive_cfg = 1'b1;
                        cfg_wr_data <= head.lim;
                    end
                end
            end
        end
        start     <= drive_start;
        cfg_wr_en <= drive_cfg;
    end

    // monitor: check results, predict accepted requests, track the limit
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n)
        begin
            if (done)
            begin
                if (result_queue.size() == 0)
                    report_mismatch("result with no request pending", 64'd1, 64'd0);
                else
                begin
                    want = result_queue.pop_front();
                    results_checked++;
                    if (ok !== want.ok)
                        report_mismatch("ok", 64'(ok), 64'(want.ok));
                    if (found_key !== want.fkey)
                        report_mismatch("found_key", 64'(found_key), 64'(want.fkey));
                    if (found_value !== want.fval)
                        report_mismatch("found_value", 64'(found_value), 64'(want.fval));
                    if (entry_total !== want.total)
                        report_mismatch("entry_total", 64'(entry_total), 64'(want.total));
                    if (is_empty !== want.empty)
                        report_mismatch("is_empty", 64'(is_empty), 64'(want.empty));
                end
            end
            item_taken = start && !busy;
            if (item_taken)
            begin
                want = predict_table(action, key, value, index);
                result_queue.push_back(want);
                requests_taken++;
                if (want.ok)
                    success_count++;
            end
            if (cfg_wr_en)
            begin
                model_limit = cfg_wr_data;
                limits_written++;
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, result_queue.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // stimulus and end of run
    initial
    begin
        logic [LIM_W-1:0] phase_limit [PHASE_COUNT];
        int               phase_ins   [PHASE_COUNT];
        int               phase_era   [PHASE_COUNT];
        int               phase_span  [PHASE_COUNT];
        logic [ACT_W-1:0] act;
        logic [KEY_BITS-1:0] k;
        int               roll;
        int               p;
        int               n;

        phase_limit = '{7'd127, 7'd3, 7'd0, 7'd64, 7'd1, 7'd40, 7'd100, 7'd64};
        phase_ins   = '{50, 35, 35, 35, 35, 35, 35, 15};
        phase_era   = '{5, 20, 20, 15, 20, 15, 15, 45};
        phase_span  = '{72, 72, 72, 24, 8, 48, 72, 72};

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (n = 2; n < POOL_SIZE; n++)
            key_pool[n] = $urandom;

        // directed: empty table, edge keys and values, duplicates, order on erase
        add_request(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000, 6'd0);
        add_request(ACT_READ,   32'h0000_0000, 32'h0000_0000, 6'd0);
        add_request(ACT_ERASE,  32'hFFFF_FFFF, 32'h0000_0000, 6'd0);
        add_request(ACT_UPDATE, 32'h0000_0000, 32'h1111_1111, 6'd0);
        add_request(ACT_INSERT, 32'h0000_0000, 32'hFFFF_FFFF, 6'd0);
        add_request(ACT_INSERT, 32'hFFFF_FFFF, 32'h0000_0000, 6'd0);
        add_request(ACT_INSERT, 32'h0000_0000, 32'h0000_1234, 6'd0);
        add_request(ACT_LOOKUP, 32'hFFFF_FFFF, 32'h0000_0000, 6'd0);
        add_request(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000, 6'd0);
        add_request(ACT_UPSERT, 32'h0000_0000, 32'hA5A5_A5A5, 6'd0);
        add_request(ACT_UPSERT, 32'h5A5A_5A5A, 32'h5A5A_5A5A, 6'd0);
        add_request(ACT_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd0);
        add_request(ACT_READ,   32'h0000_0000, 32'h0000_0000, 6'd0);
        add_request(ACT_READ,   32'h0000_0000, 32'h0000_0000, 6'd2);
        add_request(ACT_READ,   32'h0000_0000, 32'h0000_0000, 6'd3);
        add_request(ACT_READ,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63);
        add_request(ACT_RSVD_A, 32'h0000_0000, 32'hFFFF_FFFF, 6'd0);
        add_request(ACT_RSVD_B, 32'hFFFF_FFFF, 32'h0000_0000, 6'd1);
        add_request(ACT_ERASE,  32'h0000_0000, 32'h0000_0000, 6'd0);
        add_request(ACT_READ,   32'h0000_0000, 32'h0000_0000, 6'd0);
        add_request(ACT_READ,   32'h0000_0000, 32'h0000_0000, 6'd1);
        add_request(ACT_LOOKUP, 32'h0000_0000, 32'h0000_0000, 6'd0);
        add_request(ACT_ERASE,  32'h5A5A_5A5A, 32'h0000_0000, 6'd0);
        add_request(ACT_ERASE,  32'hFFFF_FFFF, 32'h0000_0000, 6'd0);

        // random phases, each under its own capacity limit
        for (p = 0; p < PHASE_COUNT; p++)
        begin
            add_config(phase_limit[p]);
            quiet_stretch = (p % 3 == 1);
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(0, 99);
                if (roll >= 97)
                    act = ($urandom_range(0, 1) != 0) ? ACT_RSVD_A : ACT_RSVD_B;
                else if (roll >= 97 - phase_era[p])
                    act = ACT_ERASE;
                else if (roll < phase_ins[p])
                    act = ACT_INSERT;
                else
                begin
                    case ($urandom_range(0, 3))
                        0:       act = ACT_UPSERT;
                        1:       act = ACT_UPDATE;
                        2:       act = ACT_LOOKUP;
                        default: act = ACT_READ;
                    endcase
                end
                if ($urandom_range(0, 99) < 85)
                    k = key_pool[$urandom_range(0, phase_span[p] - 1)];
                else
                    k = $urandom;
                add_request(act, k, $urandom,
                            INDEX_W'(($urandom_range(0, 99) < 70) ? $urandom_range(0, 15)
                                                                  : $urandom_range(0, 63)));
            end
        end

        // hold reset from the start, release it on a falling edge
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_txns.size() != 0 || start || result_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (result_queue.size() != 0)
            report_mismatch("results never returned", 64'(result_queue.size()), 64'd0);

        $display("covered %0d requests under %0d capacity writes, %0d results checked",
                 requests_taken, limits_written, results_checked);
        $display("%0d requests succeeded, table peaked at %0d of %0d entries",
                 success_count, peak_count, CAPACITY);
        if (error_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
